// ===== sv/fds_pkg.sv =====
// Shared types and constants of the 2D Yee field solver. No dependencies;
// imported by fds_cell_alu, fdtd_2d_field_solver, fds_solver_checker and tb.
package fds_pkg;

    // Fixed interface widths
    localparam int IO_W      = 24;
    localparam int COORD_W   = 6;
    localparam int CMD_W     = 3;
    localparam int COEF_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int TERM_W    = 3;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_WR_E    = 3'd0,
        CMD_WR_B    = 3'd1,
        CMD_WR_J    = 3'd2,
        CMD_RD_E    = 3'd3,
        CMD_RD_B    = 3'd4,
        CMD_ADVANCE = 3'd5,
        CMD_RD_STEP = 3'd6
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_X    = 3'd0,
        REG_HALF_Y    = 3'd1,
        REG_FULL_X    = 3'd2,
        REG_FULL_Y    = 3'd3,
        REG_TIME_STEP = 3'd4
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDOUT,
        ST_FETCH,
        ST_MUL,
        ST_WB
    } state_t;

    // Sweeps of one advance
    typedef enum logic [1:0] {
        PASS_MAG_A,
        PASS_ELEC,
        PASS_MAG_B
    } pass_t;

    // Product terms of one cell update, in issue order
    localparam logic [TERM_W-1:0] TERM_X_CURL   = 3'd0;
    localparam logic [TERM_W-1:0] TERM_X_SRC    = 3'd1;
    localparam logic [TERM_W-1:0] TERM_Y_CURL   = 3'd2;
    localparam logic [TERM_W-1:0] TERM_Y_SRC    = 3'd3;
    localparam logic [TERM_W-1:0] TERM_Z_CURL_A = 3'd4;
    localparam logic [TERM_W-1:0] TERM_Z_CURL_B = 3'd5;
    localparam logic [TERM_W-1:0] TERM_Z_SRC    = 3'd6;
    localparam logic [TERM_W-1:0] TERM_DRAIN    = 3'd7;

    // Sequencer to arithmetic unit control
    typedef struct packed {
        logic                clear;
        logic                term_valid;
        logic [TERM_W-1:0]   term_idx;
        logic                mag;
    } alu_ctrl_t;

endpackage

// ===== sv/fds_cell_alu.sv =====
// Cell update datapath: one coefficient product per cycle, per-component
// accumulators, rounding to Q.16, add to old value and saturation.
// Depends on fds_pkg.
module fds_cell_alu import fds_pkg::*; #(
    parameter int FIELD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  alu_ctrl_t                    ctrl,
    input  logic [COEF_W-1:0]            coef_x,
    input  logic [COEF_W-1:0]            coef_y,
    input  logic [COEF_W-1:0]            coef_t,
    input  logic [2:0][FIELD_BITS:0]     diff_x,
    input  logic [2:0][FIELD_BITS:0]     diff_y,
    input  logic [2:0][FIELD_BITS-1:0]   cur_j,
    input  logic [2:0][FIELD_BITS-1:0]   old_val,
    output logic [2:0][FIELD_BITS-1:0]   new_val,
    output logic                         sat
);

    localparam int OP_W   = FIELD_BITS + 2;
    localparam int PROD_W = COEF_W + 1 + OP_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SUM_W  = ACC_W + 1;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] F_MAX =
        SUM_W'((64'sd1 <<< (FIELD_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] F_MIN = -F_MAX - SUM_W'(1);

    logic signed [FIELD_BITS:0]   dx_s [3];
    logic signed [FIELD_BITS:0]   dy_s [3];
    logic signed [FIELD_BITS-1:0] j_s  [3];
    logic signed [FIELD_BITS-1:0] o_s  [3];

    logic [COEF_W-1:0]        t_coef;
    logic signed [OP_W-1:0]   t_op_raw;
    logic signed [OP_W-1:0]   t_op;
    logic                     t_neg;
    logic [1:0]               t_comp;
    logic signed [PROD_W-1:0] prod_full;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    logic [1:0]               ptag_reg;
    logic signed [ACC_W-1:0]  acc_reg [3];

    logic signed [ACC_W-1:0]  rnd  [3];
    logic signed [SUM_W-1:0]  sum  [3];
    logic [2:0]               sat_k;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dx_s[k] = $signed(diff_x[k]);
            dy_s[k] = $signed(diff_y[k]);
            j_s[k]  = $signed(cur_j[k]);
            o_s[k]  = $signed(old_val[k]);
        end
    end

    // Term select: coefficient, operand, sign and target component
    always_comb begin
        t_coef   = '0;
        t_op_raw = '0;
        t_neg    = 1'b0;
        t_comp   = 2'd0;
        case (ctrl.term_idx)
            TERM_X_CURL: begin
                t_coef = coef_y; t_op_raw = OP_W'(dy_s[2]); t_neg = ctrl.mag; t_comp = 2'd0;
            end
            TERM_X_SRC: begin
                t_coef = ctrl.mag ? '0 : coef_t; t_op_raw = OP_W'(j_s[0]);
                t_neg = 1'b1; t_comp = 2'd0;
            end
            TERM_Y_CURL: begin
                t_coef = coef_x; t_op_raw = OP_W'(dx_s[2]); t_neg = !ctrl.mag; t_comp = 2'd1;
            end
            TERM_Y_SRC: begin
                t_coef = ctrl.mag ? '0 : coef_t; t_op_raw = OP_W'(j_s[1]);
                t_neg = 1'b1; t_comp = 2'd1;
            end
            TERM_Z_CURL_A: begin
                t_coef = coef_x; t_op_raw = OP_W'(dx_s[1]); t_neg = ctrl.mag; t_comp = 2'd2;
            end
            TERM_Z_CURL_B: begin
                t_coef = coef_y; t_op_raw = OP_W'(dy_s[0]); t_neg = !ctrl.mag; t_comp = 2'd2;
            end
            TERM_Z_SRC: begin
                t_coef = ctrl.mag ? '0 : coef_t; t_op_raw = OP_W'(j_s[2]);
                t_neg = 1'b1; t_comp = 2'd2;
            end
            default: begin
                t_coef = '0; t_op_raw = '0; t_neg = 1'b0; t_comp = 2'd0;
            end
        endcase
        t_op = t_neg ? -t_op_raw : t_op_raw;
    end

    assign prod_full = $signed({1'b0, t_coef}) * t_op;

    // Product register
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= ctrl.term_valid;
        end
        prod_reg <= prod_full;
        ptag_reg <= t_comp;
    end

    // Exact Q.32 accumulation per component
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            for (int k = 0; k < 3; k++) acc_reg[k] <= '0;
        end else if (pv_reg) begin
            acc_reg[ptag_reg] <= acc_reg[ptag_reg] + ACC_W'(prod_reg);
        end
    end

    // Round half up, add old value, saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd[k] = (acc_reg[k] + HALF_LSB) >>> FRAC_BITS;
            sum[k] = SUM_W'(rnd[k]) + SUM_W'(o_s[k]);
            sat_k[k] = 1'b0;
            if (sum[k] > F_MAX) begin
                new_val[k] = F_MAX[FIELD_BITS-1:0];
                sat_k[k]   = 1'b1;
            end else if (sum[k] < F_MIN) begin
                new_val[k] = F_MIN[FIELD_BITS-1:0];
                sat_k[k]   = 1'b1;
            end else begin
                new_val[k] = sum[k][FIELD_BITS-1:0];
            end
        end
    end

    assign sat = |sat_k;

endmodule

// ===== sv/fdtd_2d_field_solver.sv =====
// Top level of the 2D Yee field solver: E, B and J grid memories, command
// sequencer and output register. Depends on fds_pkg and fds_cell_alu.
//
// After reset the block zeroes the three grid memories with s_ready low;
// configuration writes are taken meanwhile. Cell writes and the step count
// read are answered from the idle state; E/B reads first pass through the
// memory read register. An advance sweeps the grid three times (B half step,
// E full step, B half step); for each cell the sequencer reads the centre and
// two wrapped neighbours through the single read port of the source grid
// (ST_FETCH), lets the shared multiplier run seven coefficient products
// (ST_MUL) and writes back (ST_WB). One request is in work at a time; a new
// one is taken as soon as the output register is free.
module fdtd_2d_field_solver import fds_pkg::*; #(
    parameter int GRID_COLS  = 64,
    parameter int GRID_ROWS  = 64,
    parameter int FIELD_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_addr,
    input  logic [COEF_W-1:0]        cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic [COORD_W-1:0]       s_col,
    input  logic [COORD_W-1:0]       s_row,
    input  logic signed [IO_W-1:0]   s_val_x,
    input  logic signed [IO_W-1:0]   s_val_y,
    input  logic signed [IO_W-1:0]   s_val_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [IO_W-1:0]   m_out_x,
    output logic signed [IO_W-1:0]   m_out_y,
    output logic signed [IO_W-1:0]   m_out_z,
    output logic                     m_saturated
);

    localparam int CELLS      = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int VEC_W      = 3 * FIELD_BITS;
    localparam int COORD_SPAN = 1 << COORD_W;
    localparam int WIDE_W     = 34;
    localparam logic [TERM_W-1:0] FETCH_LAST = TERM_W'(3);
    localparam logic signed [WIDE_W-1:0] IO_MAX =
        WIDE_W'((64'sd1 <<< (IO_W - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] IO_MIN = -IO_MAX - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] FLD_MAX =
        WIDE_W'((64'sd1 <<< (FIELD_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] FLD_MIN = -FLD_MAX - WIDE_W'(1);

    typedef logic [2:0][FIELD_BITS-1:0] vec_t;
    typedef logic [2:0][FIELD_BITS:0]   dvec_t;

    // Stored value to output width, saturating
    function automatic logic [IO_W-1:0] to_io(input logic [FIELD_BITS-1:0] v);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'($signed(v));
        if (w > IO_MAX) return IO_MAX[IO_W-1:0];
        if (w < IO_MIN) return IO_MIN[IO_W-1:0];
        return w[IO_W-1:0];
    endfunction

    // Written value to storage width, saturating
    function automatic logic [FIELD_BITS-1:0] from_io(input logic [IO_W-1:0] v);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'($signed(v));
        if (w > FLD_MAX) return FLD_MAX[FIELD_BITS-1:0];
        if (w < FLD_MIN) return FLD_MIN[FIELD_BITS-1:0];
        return w[FIELD_BITS-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                    input logic [ROW_W-1:0] r);
        return ADDR_W'(r * GRID_COLS + c);
    endfunction

    // Configuration registers
    logic [COEF_W-1:0] half_x_reg, half_y_reg, full_x_reg, full_y_reg, tstep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_x_reg <= '0;
            half_y_reg <= '0;
            full_x_reg <= '0;
            full_y_reg <= '0;
            tstep_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_HALF_X:    half_x_reg <= cfg_wdata;
                REG_HALF_Y:    half_y_reg <= cfg_wdata;
                REG_FULL_X:    full_x_reg <= cfg_wdata;
                REG_FULL_Y:    full_y_reg <= cfg_wdata;
                REG_TIME_STEP: tstep_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Address wrap tables for request coordinates
    logic [COL_W-1:0] col_tab [COORD_SPAN];
    logic [ROW_W-1:0] row_tab [COORD_SPAN];

    always_comb begin
        for (int i = 0; i < COORD_SPAN; i++) begin
            col_tab[i] = COL_W'(i % GRID_COLS);
            row_tab[i] = ROW_W'(i % GRID_ROWS);
        end
    end

    // Sequencer state
    state_t              state_reg, state_next;
    pass_t               pass_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [TERM_W-1:0]   sub_reg;
    logic [ADDR_W-1:0]   clr_reg;
    logic                rd_sel_reg;
    logic                sat_reg;
    logic [STEP_W-1:0]   step_reg;

    logic                m_valid_reg;
    logic [IO_W-1:0]     out_x_reg, out_y_reg, out_z_reg;
    logic                out_sat_reg;

    cmd_t                cmd_in;
    logic                s_fire;
    logic [ADDR_W-1:0]   cmd_addr;
    vec_t                wr_vec;
    logic                mag;
    logic                last_cell;
    logic [COL_W-1:0]    col_inc, col_dec, col_nb;
    logic [ROW_W-1:0]    row_inc, row_dec, row_nb;
    logic [ADDR_W-1:0]   ctr_addr, src_addr;

    // Memories
    logic [VEC_W-1:0]  e_mem [CELLS];
    logic [VEC_W-1:0]  b_mem [CELLS];
    logic [VEC_W-1:0]  j_mem [CELLS];
    logic              e_we, b_we, j_we;
    logic [ADDR_W-1:0] e_waddr, b_waddr, j_waddr;
    logic [VEC_W-1:0]  e_wdata, b_wdata, j_wdata;
    logic [ADDR_W-1:0] e_raddr, b_raddr;
    logic [VEC_W-1:0]  e_rd_reg, b_rd_reg, j_rd_reg;

    // Fetched operands
    vec_t src_c_reg, src_x_reg, src_y_reg, tgt_reg, j_reg;
    vec_t src_data, tgt_data;
    dvec_t diff_x, diff_y;

    alu_ctrl_t alu_ctrl;
    vec_t      alu_new;
    logic      alu_sat;

    logic              load_out;
    logic [IO_W-1:0]   load_x, load_y, load_z;
    logic              load_sat;

    assign cmd_in   = cmd_t'(s_cmd);
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire   = s_valid && s_ready;
    assign cmd_addr = cell_addr(col_tab[s_col], row_tab[s_row]);
    assign wr_vec   = {from_io(s_val_z), from_io(s_val_y), from_io(s_val_x)};

    // Neighbor addressing with periodic wrap
    assign mag       = (pass_reg != PASS_ELEC);
    assign col_inc   = (col_reg == COL_W'(GRID_COLS - 1)) ? '0 : col_reg + COL_W'(1);
    assign col_dec   = (col_reg == '0) ? COL_W'(GRID_COLS - 1) : col_reg - COL_W'(1);
    assign row_inc   = (row_reg == ROW_W'(GRID_ROWS - 1)) ? '0 : row_reg + ROW_W'(1);
    assign row_dec   = (row_reg == '0) ? ROW_W'(GRID_ROWS - 1) : row_reg - ROW_W'(1);
    assign col_nb    = mag ? col_inc : col_dec;
    assign row_nb    = mag ? row_inc : row_dec;
    assign ctr_addr  = cell_addr(col_reg, row_reg);
    assign last_cell = (col_reg == COL_W'(GRID_COLS - 1)) &&
                       (row_reg == ROW_W'(GRID_ROWS - 1));

    always_comb begin
        case (sub_reg)
            TERM_W'(1): src_addr = cell_addr(col_nb, row_reg);
            TERM_W'(2): src_addr = cell_addr(col_reg, row_nb);
            default:    src_addr = ctr_addr;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_fire && (cmd_in == CMD_RD_E || cmd_in == CMD_RD_B)) begin
                    state_next = ST_RDOUT;
                end else if (s_fire && cmd_in == CMD_ADVANCE) begin
                    state_next = ST_FETCH;
                end
            end
            ST_RDOUT: state_next = ST_IDLE;
            ST_FETCH: if (sub_reg == FETCH_LAST) state_next = ST_MUL;
            ST_MUL:   if (sub_reg == TERM_DRAIN) state_next = ST_WB;
            ST_WB: begin
                if (last_cell && pass_reg == PASS_MAG_B) state_next = ST_IDLE;
                else                                     state_next = ST_FETCH;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory control and result load
    always_comb begin
        e_raddr = mag ? src_addr : ctr_addr;
        b_raddr = mag ? ctr_addr : src_addr;
        if (state_reg == ST_IDLE) begin
            e_raddr = cmd_addr;
            b_raddr = cmd_addr;
        end

        e_we = 1'b0; b_we = 1'b0; j_we = 1'b0;
        e_waddr = ctr_addr; b_waddr = ctr_addr; j_waddr = cmd_addr;
        e_wdata = alu_new;  b_wdata = alu_new;  j_wdata = wr_vec;

        load_out = 1'b0;
        load_x = '0; load_y = '0; load_z = '0; load_sat = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                e_we = 1'b1; b_we = 1'b1; j_we = 1'b1;
                e_waddr = clr_reg; b_waddr = clr_reg; j_waddr = clr_reg;
                e_wdata = '0; b_wdata = '0; j_wdata = '0;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    e_waddr = cmd_addr; b_waddr = cmd_addr;
                    e_wdata = wr_vec;   b_wdata = wr_vec;
                    e_we = (cmd_in == CMD_WR_E);
                    b_we = (cmd_in == CMD_WR_B);
                    j_we = (cmd_in == CMD_WR_J);
                    load_out = !(cmd_in == CMD_RD_E || cmd_in == CMD_RD_B ||
                                 cmd_in == CMD_ADVANCE);
                    if (cmd_in == CMD_RD_STEP) load_x = step_reg[IO_W-1:0];
                end
            end
            ST_RDOUT: begin
                load_out = 1'b1;
                if (rd_sel_reg) begin
                    load_x = to_io(b_rd_reg[FIELD_BITS-1:0]);
                    load_y = to_io(b_rd_reg[2*FIELD_BITS-1:FIELD_BITS]);
                    load_z = to_io(b_rd_reg[VEC_W-1:2*FIELD_BITS]);
                end else begin
                    load_x = to_io(e_rd_reg[FIELD_BITS-1:0]);
                    load_y = to_io(e_rd_reg[2*FIELD_BITS-1:FIELD_BITS]);
                    load_z = to_io(e_rd_reg[VEC_W-1:2*FIELD_BITS]);
                end
            end
            ST_WB: begin
                e_we = !mag;
                b_we = mag;
                if (last_cell && pass_reg == PASS_MAG_B) begin
                    load_out = 1'b1;
                    load_sat = sat_reg | alu_sat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (e_we) e_mem[e_waddr] <= e_wdata;
        e_rd_reg <= e_mem[e_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) b_mem[b_waddr] <= b_wdata;
        b_rd_reg <= b_mem[b_raddr];
    end

    always_ff @(posedge aclk) begin
        if (j_we) j_mem[j_waddr] <= j_wdata;
        j_rd_reg <= j_mem[ctr_addr];
    end

    // Operand capture: read data comes from the registered memory read ports
    assign src_data = mag ? e_rd_reg : b_rd_reg;
    assign tgt_data = mag ? b_rd_reg : e_rd_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH) begin
            case (sub_reg)
                TERM_W'(1): begin
                    src_c_reg <= src_data;
                    tgt_reg   <= tgt_data;
                    j_reg     <= j_rd_reg;
                end
                TERM_W'(2): src_x_reg <= src_data;
                TERM_W'(3): src_y_reg <= src_data;
                default: ;
            endcase
        end
    end

    // Forward differences for B, backward for E
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (mag) begin
                diff_x[k] = $signed({src_x_reg[k][FIELD_BITS-1], src_x_reg[k]}) -
                            $signed({src_c_reg[k][FIELD_BITS-1], src_c_reg[k]});
                diff_y[k] = $signed({src_y_reg[k][FIELD_BITS-1], src_y_reg[k]}) -
                            $signed({src_c_reg[k][FIELD_BITS-1], src_c_reg[k]});
            end else begin
                diff_x[k] = $signed({src_c_reg[k][FIELD_BITS-1], src_c_reg[k]}) -
                            $signed({src_x_reg[k][FIELD_BITS-1], src_x_reg[k]});
                diff_y[k] = $signed({src_c_reg[k][FIELD_BITS-1], src_c_reg[k]}) -
                            $signed({src_y_reg[k][FIELD_BITS-1], src_y_reg[k]});
            end
        end
    end

    assign alu_ctrl.clear      = (state_reg == ST_FETCH) && (sub_reg == '0);
    assign alu_ctrl.term_valid = (state_reg == ST_MUL) && (sub_reg != TERM_DRAIN);
    assign alu_ctrl.term_idx   = sub_reg;
    assign alu_ctrl.mag        = mag;

    fds_cell_alu #(
        .FIELD_BITS (FIELD_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (alu_ctrl),
        .coef_x  (mag ? half_x_reg : full_x_reg),
        .coef_y  (mag ? half_y_reg : full_y_reg),
        .coef_t  (tstep_reg),
        .diff_x  (diff_x),
        .diff_y  (diff_y),
        .cur_j   (j_reg),
        .old_val (tgt_reg),
        .new_val (alu_new),
        .sat     (alu_sat)
    );

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            pass_reg   <= PASS_MAG_A;
            col_reg    <= '0;
            row_reg    <= '0;
            sub_reg    <= '0;
            clr_reg    <= '0;
            rd_sel_reg <= 1'b0;
            sat_reg    <= 1'b0;
            step_reg   <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + ADDR_W'(1);
                ST_IDLE: begin
                    if (s_fire) begin
                        rd_sel_reg <= (cmd_in == CMD_RD_B);
                        pass_reg   <= PASS_MAG_A;
                        col_reg    <= '0;
                        row_reg    <= '0;
                        sub_reg    <= '0;
                        sat_reg    <= 1'b0;
                    end
                end
                ST_FETCH: sub_reg <= (sub_reg == FETCH_LAST) ? '0 : sub_reg + TERM_W'(1);
                ST_MUL:   sub_reg <= (sub_reg == TERM_DRAIN) ? '0 : sub_reg + TERM_W'(1);
                ST_WB: begin
                    sat_reg <= sat_reg | alu_sat;
                    sub_reg <= '0;
                    if (col_reg == COL_W'(GRID_COLS - 1)) begin
                        col_reg <= '0;
                        row_reg <= (row_reg == ROW_W'(GRID_ROWS - 1)) ? '0
                                                                     : row_reg + ROW_W'(1);
                    end else begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                    if (last_cell) begin
                        unique case (pass_reg)
                            PASS_MAG_A: pass_reg <= PASS_ELEC;
                            PASS_ELEC:  pass_reg <= PASS_MAG_B;
                            default:    step_reg <= step_reg + STEP_W'(1);
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load_out) begin
            out_x_reg   <= load_x;
            out_y_reg   <= load_y;
            out_z_reg   <= load_z;
            out_sat_reg <= load_sat;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_x     = $signed(out_x_reg);
    assign m_out_y     = $signed(out_y_reg);
    assign m_out_z     = $signed(out_z_reg);
    assign m_saturated = out_sat_reg;

    // Checks
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("s_ready outside idle");

    a_no_load_over_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwrites a pending result");

    a_step_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && step_reg != $past(step_reg)) |->
            ($past(state_reg == ST_WB) && $past(pass_reg == PASS_MAG_B)))
        else $error("step count changed outside end of advance");

    a_fetch_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> (sub_reg <= FETCH_LAST))
        else $error("fetch counter out of range");

endmodule

// ===== test/fds_solver_checker.sv =====
// Request/result checker for the 2D Yee field solver: keeps its own E, B, J
// grids and coefficients, predicts every result and compares. Needs fds_pkg.
module fds_solver_checker import fds_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [COEF_W-1:0]      cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [CMD_W-1:0]       s_cmd,
    input  logic [COORD_W-1:0]     s_col,
    input  logic [COORD_W-1:0]     s_row,
    input  logic signed [IO_W-1:0] s_val_x,
    input  logic signed [IO_W-1:0] s_val_y,
    input  logic signed [IO_W-1:0] s_val_z,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic signed [IO_W-1:0] m_out_x,
    input  logic signed [IO_W-1:0] m_out_y,
    input  logic signed [IO_W-1:0] m_out_z,
    input  logic                   m_saturated,
    output int                     fail_count,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL  = 64;
    localparam int NROW  = 64;
    localparam int SITES = NCOL * NROW;
    localparam longint FMAX = (64'sd1 <<< (IO_W - 1)) - 1;
    localparam longint FMIN = -FMAX - 1;

    typedef struct {
        logic [IO_W-1:0] x;
        logic [IO_W-1:0] y;
        logic [IO_W-1:0] z;
        logic            sat;
    } solver_answer_t;

    // model state
    int e_fld [3][SITES];
    int b_fld [3][SITES];
    int j_fld [3][SITES];
    longint coef [5];
    logic [STEP_W-1:0] steps;
    solver_answer_t answer_q[$];

    task automatic report(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // round the Q.32 sum to Q.16 (ties up), add, saturate
    function automatic int accum(int old, longint acc, ref bit sat);
        longint v;
        v = longint'(old) + ((acc + 32768) >>> 16);
        if (v > FMAX) begin
            sat = 1;
            v = FMAX;
        end else if (v < FMIN) begin
            sat = 1;
            v = FMIN;
        end
        return int'(v);
    endfunction

    function automatic int site(int c, int r);
        return (r % NROW) * NCOL + (c % NCOL);
    endfunction

    task automatic magnetic_half(ref bit sat);
        int o, rt, up;
        for (int r = 0; r < NROW; r++) begin
            for (int c = 0; c < NCOL; c++) begin
                o  = site(c, r);
                rt = site(c + 1, r);
                up = site(c, r + 1);
                b_fld[0][o] = accum(b_fld[0][o],
                    -coef[1] * (longint'(e_fld[2][up]) - e_fld[2][o]), sat);
                b_fld[1][o] = accum(b_fld[1][o],
                    coef[0] * (longint'(e_fld[2][rt]) - e_fld[2][o]), sat);
                b_fld[2][o] = accum(b_fld[2][o],
                    -coef[0] * (longint'(e_fld[1][rt]) - e_fld[1][o])
                    + coef[1] * (longint'(e_fld[0][up]) - e_fld[0][o]), sat);
            end
        end
    endtask

    task automatic electric_full(ref bit sat);
        int o, lf, dn;
        for (int r = 0; r < NROW; r++) begin
            for (int c = 0; c < NCOL; c++) begin
                o  = site(c, r);
                lf = site(c + NCOL - 1, r);
                dn = site(c, r + NROW - 1);
                e_fld[0][o] = accum(e_fld[0][o],
                    coef[3] * (longint'(b_fld[2][o]) - b_fld[2][dn])
                    - coef[4] * longint'(j_fld[0][o]), sat);
                e_fld[1][o] = accum(e_fld[1][o],
                    -coef[2] * (longint'(b_fld[2][o]) - b_fld[2][lf])
                    - coef[4] * longint'(j_fld[1][o]), sat);
                e_fld[2][o] = accum(e_fld[2][o],
                    coef[2] * (longint'(b_fld[1][o]) - b_fld[1][lf])
                    - coef[3] * (longint'(b_fld[0][o]) - b_fld[0][dn])
                    - coef[4] * longint'(j_fld[2][o]), sat);
            end
        end
    endtask

    // work out the result of one accepted request and apply its effect
    task automatic solve_request();
        solver_answer_t a;
        int  at;
        bit  sat;
        int  w [3];
        at  = site(s_col, s_row);
        a   = '{default: '0};
        sat = 0;
        w[0] = s_val_x;
        w[1] = s_val_y;
        w[2] = s_val_z;
        case (s_cmd)
            CMD_WR_E: for (int k = 0; k < 3; k++) e_fld[k][at] = w[k];
            CMD_WR_B: for (int k = 0; k < 3; k++) b_fld[k][at] = w[k];
            CMD_WR_J: for (int k = 0; k < 3; k++) j_fld[k][at] = w[k];
            CMD_RD_E: begin
                a.x = e_fld[0][at][IO_W-1:0];
                a.y = e_fld[1][at][IO_W-1:0];
                a.z = e_fld[2][at][IO_W-1:0];
            end
            CMD_RD_B: begin
                a.x = b_fld[0][at][IO_W-1:0];
                a.y = b_fld[1][at][IO_W-1:0];
                a.z = b_fld[2][at][IO_W-1:0];
            end
            CMD_ADVANCE: begin
                magnetic_half(sat);
                electric_full(sat);
                magnetic_half(sat);
                steps++;
                a.sat = sat;
            end
            CMD_RD_STEP: a.x = steps[IO_W-1:0];
            default: ;
        endcase
        answer_q.push_back(a);
    endtask

    initial begin
        fail_count = 0;
        outstanding = 0;
        steps = '0;
        foreach (coef[i]) coef[i] = 0;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < SITES; i++) begin
                e_fld[k][i] = 0;
                b_fld[k][i] = 0;
                j_fld[k][i] = 0;
            end
        end
    end

    // watch config, requests and results
    always @(posedge aclk) begin
        solver_answer_t a;
        if (aresetn) begin
            if (cfg_wr_en && cfg_addr <= REG_TIME_STEP)
                coef[cfg_addr] = longint'(cfg_wdata);
            if (s_valid && s_ready)
                solve_request();
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    report("unrequested result", m_out_x, 0);
                end else begin
                    a = answer_q.pop_front();
                    if (m_out_x !== a.x) report("out_x", m_out_x, a.x);
                    if (m_out_y !== a.y) report("out_y", m_out_y, a.y);
                    if (m_out_z !== a.z) report("out_z", m_out_z, a.z);
                    if (m_saturated !== a.sat) report("saturated", m_saturated, a.sat);
                end
            end
            outstanding = answer_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Top of the field solver testbench: clock, reset, request and config stimulus,
// result stalls and verdict. Needs fds_pkg, fdtd_2d_field_solver, fds_solver_checker.
module tb;
    import fds_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [COEF_W-1:0]      cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_cmd;
    logic [COORD_W-1:0]     s_col;
    logic [COORD_W-1:0]     s_row;
    logic signed [IO_W-1:0] s_val_x;
    logic signed [IO_W-1:0] s_val_y;
    logic signed [IO_W-1:0] s_val_z;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [IO_W-1:0] m_out_x;
    logic signed [IO_W-1:0] m_out_y;
    logic signed [IO_W-1:0] m_out_z;
    logic                   m_saturated;
    int                     fail_count;
    int                     outstanding;

    int burst_left;
    int sent;
    int advances;

    localparam logic [COEF_W-1:0] COEF_MAX = '1;
    localparam logic [IO_W-1:0]   VAL_MAX  = 24'h7FFFFF;
    localparam logic [IO_W-1:0]   VAL_MIN  = 24'h800000;

    fdtd_2d_field_solver uut (.*);

    fds_solver_checker chk (.*);

    always #1 aclk = ~aclk;

    // receiver stalls: a randomly drawn mode sets the m_ready pattern
    int stall_mode;
    int stall_ctr;
    always @(posedge aclk) begin
        stall_ctr <= stall_ctr + 1;
        if (stall_ctr % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= (stall_ctr % 8) != 0 && (stall_ctr % 8) != 1;
            default: m_ready <= (stall_ctr % 16) < 3;
        endcase
    end

    // write all five coefficient registers in turn
    task automatic set_coefs(logic [COEF_W-1:0] hx, logic [COEF_W-1:0] hy,
                             logic [COEF_W-1:0] fx, logic [COEF_W-1:0] fy,
                             logic [COEF_W-1:0] dt);
        logic [COEF_W-1:0] v [5];
        v = '{hx, hy, fx, fy, dt};
        for (int i = 0; i <= REG_TIME_STEP; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= reg_idx_t'(i);
            cfg_wdata <= v[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // stop sending, wait until every result is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // one request, with sender bursts and gaps
    task automatic send_req(cmd_t c, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                            logic [IO_W-1:0] x, logic [IO_W-1:0] y, logic [IO_W-1:0] z);
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            if (s_valid) s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_cmd   <= c;
        s_col   <= col;
        s_row   <= row;
        s_val_x <= x;
        s_val_y <= y;
        s_val_z <= z;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sent++;
        if (c == CMD_ADVANCE) advances++;
    endtask

    function automatic logic [IO_W-1:0] rand_val();
        case ($urandom_range(0, 7))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3: return IO_W'(int'($urandom_range(0, 4095)) - 2048);
            default: return $urandom;
        endcase
    endfunction

    // addresses near the wrap corners most of the time
    function automatic logic [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] hot [4];
        hot = '{6'd0, 6'd1, 6'd62, 6'd63};
        if ($urandom_range(0, 9) < 7) return hot[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    task automatic random_reqs(int n);
        int p;
        cmd_t c;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            if (p < 18)      c = CMD_WR_E;
            else if (p < 36) c = CMD_WR_B;
            else if (p < 52) c = CMD_WR_J;
            else if (p < 72) c = CMD_RD_E;
            else if (p < 90) c = CMD_RD_B;
            else if (p < 95) c = CMD_RD_STEP;
            else             c = cmd_t'(3'b111);
            send_req(c, rand_coord(), rand_coord(), rand_val(), rand_val(), rand_val());
        end
    endtask

    // hold off until idle, then advance and read back neighbours of the corners
    task automatic advance_and_read(int n);
        drain();
        send_req(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < n; i++)
            send_req($urandom_range(0, 1) ? CMD_RD_E : CMD_RD_B, rand_coord(), rand_coord(),
                     $urandom, $urandom, $urandom);
        send_req(CMD_RD_STEP, 0, 0, 0, 0, 0);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_cmd <= '0;
        s_col <= '0;
        s_row <= '0;
        s_val_x <= '0;
        s_val_y <= '0;
        s_val_z <= '0;
        m_ready <= 1'b0;
        stall_mode = 0;
        stall_ctr = 0;
        burst_left = 0;
        sent = 0;
        advances = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero coefficients, field extremes, every command
        set_coefs('0, '0, '0, '0, '0);
        send_req(CMD_WR_E, 0, 0, VAL_MAX, VAL_MIN, 24'h000001);
        send_req(CMD_WR_B, 63, 63, VAL_MIN, VAL_MAX, 24'hFFFFFF);
        send_req(CMD_WR_J, 63, 0, VAL_MAX, VAL_MAX, VAL_MIN);
        send_req(CMD_WR_E, 0, 63, 24'h555555, 24'hAAAAAA, 0);
        send_req(CMD_RD_E, 0, 0, 0, 0, 0);
        send_req(CMD_RD_B, 63, 63, 0, 0, 0);
        send_req(CMD_RD_E, 0, 63, 0, 0, 0);
        send_req(CMD_RD_B, 17, 40, 0, 0, 0);
        send_req(cmd_t'(3'b111), 5, 5, VAL_MAX, VAL_MAX, VAL_MAX);
        send_req(CMD_RD_E, 5, 5, 0, 0, 0);
        send_req(CMD_RD_STEP, 0, 0, 0, 0, 0);
        advance_and_read(6);

        // maximum coefficients: saturation everywhere the fields are large
        drain();
        set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        random_reqs(280);
        advance_and_read(40);

        // random coefficients
        drain();
        set_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
        random_reqs(330);
        advance_and_read(40);

        // small coefficients, mostly unsaturated updates
        drain();
        set_coefs($urandom_range(0, 4096), $urandom_range(0, 4096), $urandom_range(0, 4096),
                  $urandom_range(0, 4096), $urandom_range(0, 4096));
        random_reqs(330);
        advance_and_read(40);

        if (s_valid) s_valid <= 1'b0;
        drain();
        repeat (20) @(posedge aclk);
        $display("Covered %0d requests with %0d grid advances over 4 coefficient sets.",
                 sent, advances);
        if (fail_count == 0)
            $display("[fdtd_2d_field_solver] OK");
        else
            $display("[fdtd_2d_field_solver] ERROR");
        $finish;
    end

    // run limit, several times the slowest run
    initial begin
        #6000000;
        $display("[fdtd_2d_field_solver] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/fds_pkg.sv
sv/fds_cell_alu.sv
sv/fdtd_2d_field_solver.sv
test/fds_solver_checker.sv
test/tb.sv
